/* sv/spdf_pkg.sv */
`default_nettype none
package spdf_pkg;

  localparam int DefBufferBytes = 32;

  localparam logic [7:0]  RstStartByte    = 8'd170;
  localparam logic [15:0] RstTimeoutTicks = 16'd1000;
  localparam logic [5:0]  RstMaxLength    = 6'd32;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE    = 2'd0,
    CFG_TIMEOUT_TICKS = 2'd1,
    CFG_MAX_LENGTH    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CSUM    = 2'd1,
    ST_LEN     = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_HUNT,
    S_CMD,
    S_LEN,
    S_DATA,
    S_SUM,
    S_RD,
    S_LD,
    S_WAIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    start;     // open a frame: xor = byte, command/length/position cleared
    logic    ld_cmd;
    logic    ld_len;
    logic    wr_data;   // store payload byte, advance position
    logic    clr_idle;
    logic    inc_idle;
    logic    ld_err;
    status_e err_code;
    logic    ld_empty;
    logic    burst_clr;
    logic    burst_inc;
    logic    rd_en;
    logic    ld_item;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic is_start;
    logic len_bad;
    logic len_zero;   // stored frame length is zero
    logic byte_zero;  // incoming byte is zero
    logic pos_last;
    logic sum_ok;
    logic timeout_hit;
    logic burst_last;
    logic out_valid;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* sv/spdf_if.sv */
`default_nettype none
interface spdf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface spdf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] command;
  logic [5:0] length;
  logic [7:0] data_byte;
  logic [4:0] data_index;
  logic       last;

  modport source (output valid, output status, output command, output length,
                  output data_byte, output data_index, output last, input ready);
  modport sink   (input valid, input status, input command, input length,
                  input data_byte, input data_index, input last, output ready);
endinterface
`default_nettype wire

/* sv/serial_packet_deframer_core.sv */
`default_nettype none
// channel  dir  beat
// in_ch    in   cmd (0 byte, 1 tick), rx_byte
// out_ch   out  status, command, length, data_byte, data_index, last
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// An input beat is taken while the result register is empty and no good
// frame is draining. A good frame drains from the payload RAM one result
// beat at a time, in steps (read, load, wait for the result register);
// error and empty-frame results are loaded straight into the result register.
// Input is held off while a result is pending. Reset is asynchronous, active
// low; the payload RAM is never cleared, each entry is written before read.
module serial_packet_deframer_core #(
  parameter int BUFFER_BYTES = spdf_pkg::DefBufferBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  spdf_in_if.sink                            in_ch,
  spdf_out_if.source                         out_ch,
  input  wire logic                          cfg_we_i,
  input  wire logic [spdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [spdf_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import spdf_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  spdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  spdf_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_cmd_i         (in_ch.cmd),
    .in_byte_i        (in_ch.rx_byte),
    .out_ready_i      (out_ch.ready),
    .out_valid_o      (out_ch.valid),
    .out_status_o     (out_ch.status),
    .out_command_o    (out_ch.command),
    .out_length_o     (out_ch.length),
    .out_data_byte_o  (out_ch.data_byte),
    .out_data_index_o (out_ch.data_index),
    .out_last_o       (out_ch.last),
    .cmd_i            (ctrl_cmd),
    .stat_o           (dp_stat)
  );

endmodule
`default_nettype wire

/* sv/spdf_ram.sv */
`default_nettype none
module spdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/spdf_ctrl.sv */
`default_nettype none
module spdf_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire spdf_pkg::dp_stat_t    stat_i,
  output spdf_pkg::ctrl_cmd_t        cmd_o
);
  import spdf_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.err_code = ST_OK;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_HUNT, S_CMD, S_LEN, S_DATA, S_SUM: in_ready_o = !stat_i.out_valid;
      S_RD, S_LD, S_WAIT:                  in_ready_o = 1'b0;
      default:                             in_ready_o = 1'b0;
    endcase
    accept = in_valid_i && in_ready_o;

    unique case (state_q)
      S_HUNT: begin
        if (accept && !stat_i.is_tick && stat_i.is_start) begin
          cmd_o.start    = 1'b1;
          cmd_o.clr_idle = 1'b1;
          state_d        = S_CMD;
        end
      end
      S_CMD, S_LEN, S_DATA, S_SUM: begin
        if (accept && stat_i.is_tick) begin
          cmd_o.inc_idle = 1'b1;
          if (stat_i.timeout_hit) begin
            cmd_o.ld_err   = 1'b1;
            cmd_o.err_code = ST_TIMEOUT;
            cmd_o.clr_idle = 1'b1;
            state_d        = S_HUNT;
          end
        end else if (accept) begin
          cmd_o.clr_idle = 1'b1;
          unique case (state_q)
            S_CMD: begin
              cmd_o.ld_cmd = 1'b1;
              state_d      = S_LEN;
            end
            S_LEN: begin
              if (stat_i.len_bad) begin
                cmd_o.ld_err   = 1'b1;
                cmd_o.err_code = ST_LEN;
                state_d        = S_HUNT;
              end else begin
                cmd_o.ld_len = 1'b1;
                state_d      = stat_i.byte_zero ? S_SUM : S_DATA;
              end
            end
            S_DATA: begin
              cmd_o.wr_data = 1'b1;
              if (stat_i.pos_last) begin
                state_d = S_SUM;
              end
            end
            default: begin
              if (!stat_i.sum_ok) begin
                cmd_o.ld_err   = 1'b1;
                cmd_o.err_code = ST_CSUM;
                state_d        = S_HUNT;
              end else if (stat_i.len_zero) begin
                cmd_o.ld_empty = 1'b1;
                state_d        = S_HUNT;
              end else begin
                cmd_o.burst_clr = 1'b1;
                state_d         = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LD;
      end
      S_LD: begin
        cmd_o.ld_item = 1'b1;
        if (stat_i.burst_last) begin
          state_d = S_HUNT;
        end else begin
          cmd_o.burst_inc = 1'b1;
          state_d         = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat_i.out_free) begin
          state_d = S_RD;
        end
      end
      default: state_d = S_HUNT;
    endcase
  end

endmodule
`default_nettype wire

/* sv/spdf_dp.sv */
`default_nettype none
module spdf_dp #(
  parameter int BUFFER_BYTES = spdf_pkg::DefBufferBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [spdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [spdf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_cmd_i,
  input  wire logic [7:0]                    in_byte_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [1:0]                         out_status_o,
  output logic [7:0]                         out_command_o,
  output logic [5:0]                         out_length_o,
  output logic [7:0]                         out_data_byte_o,
  output logic [4:0]                         out_data_index_o,
  output logic                               out_last_o,
  input  wire spdf_pkg::ctrl_cmd_t           cmd_i,
  output spdf_pkg::dp_stat_t                 stat_o
);
  import spdf_pkg::*;

  localparam int         AW       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [7:0] BufLimit = 8'(BUFFER_BYTES);

  // configuration
  logic [7:0]  start_byte_q;
  logic [15:0] timeout_q;
  logic [5:0]  max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= RstStartByte;
      timeout_q    <= RstTimeoutTicks;
      max_len_q    <= RstMaxLength;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_BYTE:    start_byte_q <= cfg_wdata_i[7:0];
        CFG_TIMEOUT_TICKS: timeout_q    <= cfg_wdata_i;
        CFG_MAX_LENGTH:    max_len_q    <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic [7:0]  fcmd_q;
  logic [5:0]  flen_q;
  logic [5:0]  pos_q;
  logic [7:0]  xor_q;
  logic [15:0] idle_q;
  logic [5:0]  bidx_q;

  logic [15:0] idle_inc;
  logic [5:0]  pos_inc;
  logic [5:0]  bidx_inc;
  logic [7:0]  limit;
  logic [5:0]  len_sat;

  assign idle_inc = idle_q + 16'd1;
  assign pos_inc  = pos_q + 6'd1;
  assign bidx_inc = bidx_q + 6'd1;
  assign limit    = ({2'b00, max_len_q} > BufLimit) ? BufLimit : {2'b00, max_len_q};
  assign len_sat  = (in_byte_i > 8'd63) ? 6'd63 : in_byte_i[5:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcmd_q <= '0;
      flen_q <= '0;
      pos_q  <= '0;
      xor_q  <= '0;
      idle_q <= '0;
      bidx_q <= '0;
    end else begin
      if (cmd_i.start) begin
        fcmd_q <= '0;
        flen_q <= '0;
        pos_q  <= '0;
        xor_q  <= in_byte_i;
      end
      if (cmd_i.ld_cmd) begin
        fcmd_q <= in_byte_i;
        xor_q  <= xor_q ^ in_byte_i;
      end
      if (cmd_i.ld_len) begin
        flen_q <= in_byte_i[5:0];
        xor_q  <= xor_q ^ in_byte_i;
        pos_q  <= '0;
      end
      if (cmd_i.wr_data) begin
        xor_q <= xor_q ^ in_byte_i;
        pos_q <= pos_inc;
      end
      if (cmd_i.clr_idle) begin
        idle_q <= '0;
      end else if (cmd_i.inc_idle) begin
        idle_q <= idle_inc;
      end
      if (cmd_i.burst_clr) begin
        bidx_q <= '0;
      end else if (cmd_i.burst_inc) begin
        bidx_q <= bidx_inc;
      end
    end
  end

  logic [7:0] rdata;

  spdf_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_data),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (in_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (bidx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_err || cmd_i.ld_empty || cmd_i.ld_item) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_err) begin
      out_status_o     <= cmd_i.err_code;
      out_command_o    <= fcmd_q;
      out_length_o     <= (cmd_i.err_code == ST_LEN) ? len_sat : flen_q;
      out_data_byte_o  <= '0;
      out_data_index_o <= '0;
      out_last_o       <= 1'b1;
    end else if (cmd_i.ld_empty) begin
      out_status_o     <= ST_OK;
      out_command_o    <= fcmd_q;
      out_length_o     <= '0;
      out_data_byte_o  <= '0;
      out_data_index_o <= '0;
      out_last_o       <= 1'b1;
    end else if (cmd_i.ld_item) begin
      out_status_o     <= ST_OK;
      out_command_o    <= fcmd_q;
      out_length_o     <= flen_q;
      out_data_byte_o  <= rdata;
      out_data_index_o <= bidx_q[4:0];
      out_last_o       <= (bidx_inc == flen_q);
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o             = '0;
    stat_o.is_tick     = in_cmd_i;
    stat_o.is_start    = (in_byte_i == start_byte_q);
    stat_o.len_bad     = (in_byte_i > limit);
    stat_o.len_zero    = (flen_q == 6'd0);
    stat_o.byte_zero   = (in_byte_i == 8'd0);
    stat_o.pos_last    = (pos_inc >= flen_q);
    stat_o.sum_ok      = (in_byte_i == xor_q);
    stat_o.timeout_hit = (idle_inc >= timeout_q);
    stat_o.burst_last  = (bidx_inc == flen_q);
    stat_o.out_valid   = out_valid_q;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire
